[src/lsp_pkg.sv]
`default_nettype none

package lsp_pkg;

    // Window geometry
    localparam int MAX_WINDOW = 64;
    localparam int WIN_AW     = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

    // Field and register widths
    localparam int POS_W    = 12;
    localparam int GAIN_W   = 24;
    localparam int CREF_W   = 10;
    localparam int WLEN_W   = 7;
    localparam int ANGLE_W  = 32;
    localparam int ERR_W    = 13;
    localparam int DIFF_W   = 14;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 24;

    // Accumulator and divider widths
    localparam int DEN_MAX   = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int DEN_W     = $clog2(DEN_MAX + 1);
    localparam int PSUM_W    = ANGLE_W + WIN_AW;
    localparam int WSUM_W    = ANGLE_W + DEN_W;
    localparam int WPROD_W   = ANGLE_W + FILL_W + 1;
    localparam int DIV_CNT_W = $clog2(WSUM_W);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_KP   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KI   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KD   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CREF = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_WLEN = 3'd4;

    // Configuration reset values
    localparam logic signed [GAIN_W-1:0] KP_RESET   = 24'sd32768;
    localparam logic signed [GAIN_W-1:0] KI_RESET   = 24'sd33;
    localparam logic signed [GAIN_W-1:0] KD_RESET   = 24'sd3277;
    localparam logic [CREF_W-1:0]        CREF_RESET = 10'd320;
    localparam logic [WLEN_W-1:0]        WLEN_RESET = 7'd50;

    typedef struct packed {
        logic signed [POS_W-1:0] left_pos;
        logic signed [POS_W-1:0] right_pos;
    } t_in;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] steer_angle;
        logic signed [ANGLE_W-1:0] smoothed_angle;
    } t_out;

endpackage

`default_nettype wire

[src/lane_steer_pid_smoother_core.sv]
// Lane-keeping PID step with a linearly weighted moving average of the angle.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries the left and
// right lane positions of one frame. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns the saturated Q16.16 steering angle and
// its weighted moving average, one result per input transaction.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) take effect at
// once; the user must make them while the block is idle (the block does not
// enforce it); a window length write empties the window, keeping PID state.
//
// One item is processed at a time. An accepted item passes through the PID
// and window arithmetic (the window sits in a 64 x 32 memory with registered
// read), then a restoring divider that retires one quotient bit per cycle
// over the 44-bit weighted sum, before its result is loaded into the output
// register. The next item is accepted in the cycle after the result is
// loaded, even while that result is still waiting.
// If the receiver stalls, a finished result waits in the processing pipeline
// until the output register frees up. Reset clears the gains to their
// defaults, the error history, the integral and the window; no clearing pass.

`default_nettype none

module lane_steer_pid_smoother_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire lsp_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output lsp_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [lsp_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [lsp_pkg::CFG_DW-1:0]     i_cfg_wdata
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PID     = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_SUM     = 4'd3;
    localparam logic [3:0] S_WMUL    = 4'd4;
    localparam logic [3:0] S_ACC     = 4'd5;
    localparam logic [3:0] S_DIVGO   = 4'd6;
    localparam logic [3:0] S_DIVWAIT = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    localparam int SUM_W = 58;
    localparam logic signed [SUM_W-1:0] SAT_HI = 58'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO = -58'sd2147483648;
    localparam logic [lsp_pkg::FILL_W-1:0] LEN_MAX =
        lsp_pkg::FILL_W'(lsp_pkg::MAX_WINDOW);

    function automatic logic signed [lsp_pkg::ANGLE_W-1:0] sat32(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [lsp_pkg::ANGLE_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[lsp_pkg::ANGLE_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[lsp_pkg::ANGLE_W-1:0];
        end else begin
            res = v[lsp_pkg::ANGLE_W-1:0];
        end
        return res;
    endfunction

    // Configuration registers
    logic signed [lsp_pkg::GAIN_W-1:0]  r_kp;
    logic signed [lsp_pkg::GAIN_W-1:0]  r_ki;
    logic signed [lsp_pkg::GAIN_W-1:0]  r_kd;
    logic [lsp_pkg::CREF_W-1:0]         r_cref;
    logic [lsp_pkg::WLEN_W-1:0]         r_wlen;

    // Control and PID state
    logic [3:0]                         r_state;
    logic [3:0]                         n_state;
    logic signed [lsp_pkg::ERR_W-1:0]   r_err;
    logic signed [lsp_pkg::ERR_W-1:0]   r_last_err;
    logic signed [lsp_pkg::DIFF_W-1:0]  r_diff;
    logic signed [lsp_pkg::ANGLE_W-1:0] r_integ;
    logic signed [36:0]                 r_p_kp;
    logic signed [55:0]                 r_p_ki;
    logic signed [37:0]                 r_p_kd;
    logic signed [lsp_pkg::ANGLE_W-1:0] r_angle;
    logic signed [lsp_pkg::ANGLE_W-1:0] r_avg;

    // Window state
    logic [lsp_pkg::ANGLE_W-1:0]        r_win_mem [lsp_pkg::MAX_WINDOW];
    logic [lsp_pkg::ANGLE_W-1:0]        r_rd_data;
    logic [lsp_pkg::FILL_W-1:0]         r_fill;
    logic [lsp_pkg::WIN_AW-1:0]         r_oldest;
    logic signed [lsp_pkg::PSUM_W-1:0]  r_psum;
    logic signed [lsp_pkg::WSUM_W-1:0]  r_wsum;
    logic signed [lsp_pkg::WPROD_W-1:0] r_wprod;
    logic [lsp_pkg::DEN_W-1:0]          r_den;

    // Output register
    logic                               r_out_valid;
    lsp_pkg::t_out                      r_out;

    // Combinational signals
    logic                               w_in_acc;
    logic                               w_out_free;
    logic signed [lsp_pkg::ERR_W-1:0]   w_pos_sum;
    logic signed [lsp_pkg::ERR_W-1:0]   w_pos_rnd;
    logic signed [lsp_pkg::POS_W-1:0]   w_mid;
    logic signed [lsp_pkg::ERR_W-1:0]   w_err;
    logic signed [SUM_W-1:0]            w_integ_sum;
    logic signed [SUM_W-1:0]            w_ang_sum;
    logic [lsp_pkg::FILL_W-1:0]         w_wlen_ext;
    logic [lsp_pkg::FILL_W-1:0]         w_len;
    logic                               w_fill_mode;
    logic [lsp_pkg::FILL_W:0]           w_slot_sum;
    logic [lsp_pkg::WIN_AW-1:0]         w_slot;
    logic [lsp_pkg::FILL_W-1:0]         w_oldest_inc;
    logic [lsp_pkg::FILL_W-1:0]         w_factor;
    logic [lsp_pkg::FILL_W-1:0]         w_n;
    logic [lsp_pkg::DEN_W:0]            w_den_prod;
    logic                               w_div_done;
    logic signed [lsp_pkg::ANGLE_W-1:0] w_div_q;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Midpoint truncated toward zero: add one to a negative sum before halving.
    assign w_pos_sum = lsp_pkg::ERR_W'(i_in_data.left_pos) +
                       lsp_pkg::ERR_W'(i_in_data.right_pos);
    assign w_pos_rnd = w_pos_sum + {{(lsp_pkg::ERR_W-1){1'b0}}, w_pos_sum[lsp_pkg::ERR_W-1]};
    assign w_mid     = w_pos_rnd[lsp_pkg::ERR_W-1:1];
    assign w_err     = $signed({{(lsp_pkg::ERR_W-lsp_pkg::CREF_W){1'b0}}, r_cref}) -
                       lsp_pkg::ERR_W'(w_mid);

    assign w_integ_sum = SUM_W'(r_integ) + SUM_W'(r_err);
    assign w_ang_sum   = SUM_W'(r_p_kp) + SUM_W'(r_p_ki) + SUM_W'(r_p_kd);

    // Effective window length: zero counts as one, large values clamp.
    assign w_wlen_ext = lsp_pkg::FILL_W'(r_wlen);
    always_comb begin
        if (r_wlen == '0) begin
            w_len = lsp_pkg::FILL_W'(1);
        end else if (w_wlen_ext > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = w_wlen_ext;
        end
    end

    assign w_fill_mode  = (r_fill < w_len);
    assign w_slot_sum   = {1'b0, lsp_pkg::FILL_W'(r_oldest)} + {1'b0, r_fill};
    assign w_oldest_inc = lsp_pkg::FILL_W'(r_oldest) + 1'b1;

    always_comb begin
        if (!w_fill_mode) begin
            w_slot = r_oldest;
        end else if (w_slot_sum >= {1'b0, w_len}) begin
            w_slot = lsp_pkg::WIN_AW'(w_slot_sum - {1'b0, w_len});
        end else begin
            w_slot = lsp_pkg::WIN_AW'(w_slot_sum);
        end
    end

    assign w_factor   = w_fill_mode ? (r_fill + 1'b1) : w_len;
    assign w_n        = w_fill_mode ? (r_fill + 1'b1) : r_fill;
    assign w_den_prod = (lsp_pkg::DEN_W + 1)'(w_n) * (lsp_pkg::DEN_W + 1)'(w_n + 1'b1);

    lsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVGO),
        .i_dividend (r_wsum),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_PID;
            S_PID:     n_state = S_MUL;
            S_MUL:     n_state = S_SUM;
            S_SUM:     n_state = S_WMUL;
            S_WMUL:    n_state = S_ACC;
            S_ACC:     n_state = S_DIVGO;
            S_DIVGO:   n_state = S_DIVWAIT;
            S_DIVWAIT: if (w_div_done) n_state = S_OUT;
            S_OUT:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kp        <= lsp_pkg::KP_RESET;
            r_ki        <= lsp_pkg::KI_RESET;
            r_kd        <= lsp_pkg::KD_RESET;
            r_cref      <= lsp_pkg::CREF_RESET;
            r_wlen      <= lsp_pkg::WLEN_RESET;
            r_last_err  <= '0;
            r_integ     <= '0;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_psum      <= '0;
            r_wsum      <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_PID) begin
                r_last_err <= r_err;
                r_integ    <= sat32(w_integ_sum);
            end

            if (r_state == S_ACC) begin
                if (w_fill_mode) begin
                    r_fill <= r_fill + 1'b1;
                    r_psum <= r_psum + lsp_pkg::PSUM_W'(r_angle);
                    r_wsum <= r_wsum + lsp_pkg::WSUM_W'(r_wprod);
                end else begin
                    // Shifting every weight down by one drops plain_sum once.
                    r_wsum   <= r_wsum - lsp_pkg::WSUM_W'(r_psum) +
                                lsp_pkg::WSUM_W'(r_wprod);
                    r_psum   <= r_psum - lsp_pkg::PSUM_W'($signed(r_rd_data)) +
                                lsp_pkg::PSUM_W'(r_angle);
                    r_oldest <= (w_oldest_inc == w_len) ? '0 :
                                lsp_pkg::WIN_AW'(w_oldest_inc);
                end
            end

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    lsp_pkg::CFG_KP:   r_kp   <= $signed(i_cfg_wdata[lsp_pkg::GAIN_W-1:0]);
                    lsp_pkg::CFG_KI:   r_ki   <= $signed(i_cfg_wdata[lsp_pkg::GAIN_W-1:0]);
                    lsp_pkg::CFG_KD:   r_kd   <= $signed(i_cfg_wdata[lsp_pkg::GAIN_W-1:0]);
                    lsp_pkg::CFG_CREF: r_cref <= i_cfg_wdata[lsp_pkg::CREF_W-1:0];
                    lsp_pkg::CFG_WLEN: begin
                        r_wlen   <= i_cfg_wdata[lsp_pkg::WLEN_W-1:0];
                        r_fill   <= '0;
                        r_oldest <= '0;
                        r_psum   <= '0;
                        r_wsum   <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= w_err;
        end
        if (r_state == S_PID) begin
            r_diff <= lsp_pkg::DIFF_W'(r_err) - lsp_pkg::DIFF_W'(r_last_err);
        end
        if (r_state == S_MUL) begin
            r_p_kp <= r_kp * r_err;
            r_p_ki <= r_ki * r_integ;
            r_p_kd <= r_kd * r_diff;
        end
        if (r_state == S_SUM) begin
            r_angle <= sat32(w_ang_sum);
        end
        if (r_state == S_WMUL) begin
            r_wprod <= $signed({1'b0, w_factor}) * r_angle;
        end
        if (r_state == S_ACC) begin
            r_den <= w_den_prod[lsp_pkg::DEN_W:1];
        end
        if (r_state == S_DIVWAIT && w_div_done) begin
            r_avg <= w_div_q;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out.steer_angle    <= r_angle;
            r_out.smoothed_angle <= r_avg;
        end
    end

    // Window memory. The oldest sample is read in S_SUM, the cycle before the new
    // angle overwrites the same slot in S_WMUL, so they never collide in a cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_rd_data <= r_win_mem[r_oldest];
        end
        if (r_state == S_WMUL) begin
            r_win_mem[w_slot] <= r_angle;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[src/lsp_div.sv]
`default_nettype none

module lsp_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [lsp_pkg::WSUM_W-1:0]   i_dividend,
    input  wire logic [lsp_pkg::DEN_W-1:0]           i_divisor,
    output logic                                     o_done,
    output logic signed [lsp_pkg::ANGLE_W-1:0]       o_quotient
);

    localparam logic [lsp_pkg::DIV_CNT_W-1:0] LAST_STEP =
        lsp_pkg::DIV_CNT_W'(lsp_pkg::WSUM_W - 1);

    logic                             r_busy;
    logic                             r_done;
    logic [lsp_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [lsp_pkg::DEN_W-1:0]        r_rem;
    logic [lsp_pkg::WSUM_W-1:0]       r_quo;
    logic [lsp_pkg::DEN_W-1:0]        r_div;
    logic                             r_neg;

    logic [lsp_pkg::DEN_W:0]          w_shift;
    logic [lsp_pkg::DEN_W:0]          w_diff;
    logic                             w_fits;
    logic [lsp_pkg::WSUM_W-1:0]       w_mag;
    logic [lsp_pkg::WSUM_W-1:0]       w_quo_signed;

    assign w_mag   = i_dividend[lsp_pkg::WSUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_shift = {r_rem, r_quo[lsp_pkg::WSUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fits  = (w_shift >= {1'b0, r_div});

    // Restoring division on the magnitude, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[lsp_pkg::WSUM_W-1];
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= w_diff[lsp_pkg::DEN_W-1:0];
            end else begin
                r_rem <= w_shift[lsp_pkg::DEN_W-1:0];
            end
            r_quo <= {r_quo[lsp_pkg::WSUM_W-2:0], w_fits};
        end
    end

    // The average always fits the angle range, so the low bits carry it.
    assign w_quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quotient   = w_quo_signed[lsp_pkg::ANGLE_W-1:0];
    assign o_done       = r_done;

endmodule

`default_nettype wire

[src/lsp_checker.sv]
`default_nettype none

module lsp_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_ready,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire lsp_pkg::t_out                  o_out_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // One item at a time: an accepted transaction closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // A new result is only produced by an item in flight.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no item in flight");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind lane_steer_pid_smoother_core lsp_checker u_lsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
